[rtl/pnot_pkg.sv]
// pnot_pkg: shared types, constants and register map of the note tracker
// used by every module of the tracker; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package pnot_pkg;

	// frame counter width and the compare width for the length limit
	localparam int FRAME_BITS = 16;
	localparam int MAXLEN_BITS = 16;
	localparam int CMP_BITS = (FRAME_BITS > MAXLEN_BITS) ? FRAME_BITS : MAXLEN_BITS;

	typedef logic [FRAME_BITS-1:0] frame_t;

	// configuration register map (word index into the APB space)
	localparam int PADDR_BITS = 4;
	localparam logic [1:0] REG_DROP_LEVEL = 2'd0;
	localparam logic [1:0] REG_MAX_NOTE_FRAMES = 2'd1;
	localparam logic [1:0] REG_VELOCITY_SCALE = 2'd2;
	localparam logic [1:0] REG_LOWEST_PITCH = 2'd3;

	// register reset values
	localparam logic [15:0] RST_DROP_LEVEL = 16'd32768;
	localparam logic [15:0] RST_MAX_NOTE_FRAMES = 16'd600;
	localparam logic [7:0] RST_VELOCITY_SCALE = 8'd128;
	localparam logic [6:0] RST_LOWEST_PITCH = 7'd21;

	typedef struct packed {
		logic [15:0] drop_level;
		logic [15:0] max_note_frames;
		logic [7:0] velocity_scale;
		logic [6:0] lowest_pitch;
	} cfg_t;

	// one frame of one pitch stream
	typedef struct packed {
		logic first_frame;
		logic last_frame;
		logic [6:0] pitch_index;
		logic [15:0] frame_prob;
		logic onset_flag;
		logic signed [15:0] onset_shift;
		logic offset_flag;
		logic signed [15:0] offset_shift;
		logic [15:0] velocity_prob;
	} frame_item_t;

	// one closed note
	typedef struct packed {
		logic [15:0] note_start_frame;
		logic [15:0] note_end_frame;
		logic [7:0] note_number;
		logic signed [15:0] start_shift;
		logic signed [15:0] end_shift;
		logic [7:0] note_velocity;
	} note_item_t;

endpackage

`default_nettype wire

[rtl/pnot_cfg_regs.sv]
// pnot_cfg_regs: APB register file holding the tracker configuration
// depends on pnot_pkg
`timescale 1ns / 1ps
`default_nettype none

module pnot_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [pnot_pkg::PADDR_BITS-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output pnot_pkg::cfg_t cfg
);

	pnot_pkg::cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg = cfg_q;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drop_level <= pnot_pkg::RST_DROP_LEVEL;
			cfg_q.max_note_frames <= pnot_pkg::RST_MAX_NOTE_FRAMES;
			cfg_q.velocity_scale <= pnot_pkg::RST_VELOCITY_SCALE;
			cfg_q.lowest_pitch <= pnot_pkg::RST_LOWEST_PITCH;
		end else if (wr_en) begin
			unique case (reg_idx)
				pnot_pkg::REG_DROP_LEVEL: cfg_q.drop_level <= pwdata[15:0];
				pnot_pkg::REG_MAX_NOTE_FRAMES: cfg_q.max_note_frames <= pwdata[15:0];
				pnot_pkg::REG_VELOCITY_SCALE: cfg_q.velocity_scale <= pwdata[7:0];
				pnot_pkg::REG_LOWEST_PITCH: cfg_q.lowest_pitch <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			pnot_pkg::REG_DROP_LEVEL: prdata = {16'd0, cfg_q.drop_level};
			pnot_pkg::REG_MAX_NOTE_FRAMES: prdata = {16'd0, cfg_q.max_note_frames};
			pnot_pkg::REG_VELOCITY_SCALE: prdata = {24'd0, cfg_q.velocity_scale};
			pnot_pkg::REG_LOWEST_PITCH: prdata = {25'd0, cfg_q.lowest_pitch};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/pnot_core.sv]
// pnot_core: open-note state and the single-pass decision for one frame
// depends on pnot_pkg
`timescale 1ns / 1ps
`default_nettype none

module pnot_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire pnot_pkg::frame_item_t item,
	input wire pnot_pkg::cfg_t cfg,
	output logic emit,
	output pnot_pkg::note_item_t note
);

	localparam int CMP_BITS = pnot_pkg::CMP_BITS;

	// tracker state
	pnot_pkg::frame_t frame_q;
	logic open_q;
	logic seen_q;
	pnot_pkg::frame_t start_frame_q;
	logic [15:0] start_shift_q;
	logic [15:0] velocity_q;
	pnot_pkg::frame_t seen_frame_q;
	logic [15:0] seen_shift_q;

	// next-state values
	pnot_pkg::frame_t idx;
	logic open_eff;
	logic seen_eff;
	logic open_d;
	logic seen_d;
	logic load_start;
	logic load_seen;
	pnot_pkg::frame_t elapsed;
	pnot_pkg::frame_t seen_frame_n;
	logic [15:0] seen_shift_n;
	pnot_pkg::frame_t to_start;
	pnot_pkg::frame_t to_drop;
	logic drop;
	logic too_long;
	pnot_pkg::frame_t end_frame;
	logic [15:0] end_shift;
	logic [23:0] vel_prod;

	// first frame of a stream clears the counter and any open note
	assign idx = item.first_frame ? '0 : frame_q;
	assign open_eff = item.first_frame ? 1'b0 : open_q;
	assign seen_eff = item.first_frame ? 1'b0 : seen_q;

	assign elapsed = idx - start_frame_q;
	assign drop = item.frame_prob <= cfg.drop_level;
	assign too_long = CMP_BITS'(elapsed) >= CMP_BITS'(cfg.max_note_frames);

	// first offset peak since the onset, including this frame
	assign load_seen = item.offset_flag & ~seen_eff;
	assign seen_frame_n = load_seen ? idx : seen_frame_q;
	assign seen_shift_n = load_seen ? item.offset_shift : seen_shift_q;
	assign to_start = seen_frame_n - start_frame_q;
	assign to_drop = idx - seen_frame_n;

	// close decision
	always_comb begin
		emit = 1'b0;
		open_d = open_eff;
		seen_d = seen_eff;
		load_start = 1'b0;
		end_frame = idx;
		end_shift = item.offset_shift;
		if (item.onset_flag) begin
			// re-onset closes the open note at the previous frame
			emit = open_eff;
			end_frame = (idx == '0) ? '0 : idx - 1'b1;
			end_shift = '0;
			open_d = 1'b1;
			seen_d = 1'b0;
			load_start = 1'b1;
		end else if (open_eff && elapsed != '0) begin
			seen_d = seen_eff | item.offset_flag;
			if (drop) begin
				emit = 1'b1;
				open_d = 1'b0;
				seen_d = 1'b0;
				if ((seen_eff | item.offset_flag) && to_start > to_drop) begin
					end_frame = seen_frame_n;
					end_shift = seen_shift_n;
				end
			end else if (too_long || item.last_frame) begin
				emit = 1'b1;
				open_d = 1'b0;
				seen_d = 1'b0;
			end
		end
	end

	// result fields
	assign vel_prod = velocity_q * cfg.velocity_scale;
	always_comb begin
		note.note_start_frame = 16'(start_frame_q);
		note.note_end_frame = 16'(end_frame);
		note.note_number = {1'b0, item.pitch_index} + {1'b0, cfg.lowest_pitch};
		note.start_shift = start_shift_q;
		note.end_shift = end_shift;
		note.note_velocity = vel_prod[23:16];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			open_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (go) begin
			frame_q <= idx + 1'b1;
			open_q <= open_d;
			seen_q <= seen_d;
		end
	end

	// open-note payload
	always_ff @(posedge clk) begin
		if (go && load_start) begin
			start_frame_q <= idx;
			start_shift_q <= item.onset_shift;
			velocity_q <= item.velocity_prob;
		end
		if (go && !item.onset_flag && open_eff && elapsed != '0 && load_seen) begin
			seen_frame_q <= idx;
			seen_shift_q <= item.offset_shift;
		end
	end

endmodule

`default_nettype wire

[rtl/piano_note_onset_offset_tracker.sv]
// piano_note_onset_offset_tracker: top level with input and result registers
// depends on pnot_pkg, pnot_cfg_regs and pnot_core
`timescale 1ns / 1ps
`default_nettype none

// Usage
// frame channel (frame_valid / frame_ready / frame) carries one frame of one
// pitch stream; first_frame starts a stream, last_frame ends it.
// note channel (note_valid / note_ready / note) carries each closed note,
// zero or one per frame, in frame order.
// A note caused by a frame passes two registers: the frame's transfer
// loads the input register, and the note then moves into the result
// register as soon as that register can take it.
// Throughput: one frame per cycle when not stalled; the tracker state loops
// through one compare/subtract pass and a 16x8 velocity multiply per frame.
// A stalled note channel holds the result register; the input register
// then holds too, so frame_ready drops after at most one more transfer.
// Reset clears both valid bits, the frame counter and the open note, loads
// config defaults. The user must write the APB port only while idle; the block does not enforce it.

module piano_note_onset_offset_tracker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [pnot_pkg::PADDR_BITS-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic frame_valid,
	output logic frame_ready,
	input wire pnot_pkg::frame_item_t frame,
	output logic note_valid,
	input wire logic note_ready,
	output pnot_pkg::note_item_t note
);

	pnot_pkg::cfg_t cfg;
	pnot_pkg::frame_item_t frame_s1;
	logic valid_s1;
	logic out_free;
	logic advance;
	logic emit;
	pnot_pkg::note_item_t note_n;
	pnot_pkg::note_item_t note_q;
	logic note_valid_q;

	pnot_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// stage 1 frame moves on whenever the result register can take a transfer
	assign out_free = ~note_valid_q | note_ready;
	assign advance = valid_s1 & out_free;
	assign frame_ready = ~valid_s1 | out_free;

	pnot_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.go(advance),
		.item(frame_s1),
		.cfg(cfg),
		.emit(emit),
		.note(note_n)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_ready) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_ready && frame_valid) begin
			frame_s1 <= frame;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_valid_q <= 1'b0;
		end else if (out_free) begin
			note_valid_q <= advance & emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			note_q <= note_n;
		end
	end

	assign note_valid = note_valid_q;
	assign note = note_q;

endmodule

`default_nettype wire
